### rtl/lhm_pkg.sv
// Shared types and constants for the latency histogram monitor.
// Used by lhm_bin_locate, latency_histogram_monitor and the testbench; depends on nothing.
package lhm_pkg;

  // Histogram geometry.
  localparam int NUM_BINS          = 20;
  localparam int DEF_COUNT_WIDTH   = 32;
  localparam int BIN_IDX_W         = 5;
  localparam int BIN_ADDR_W        = $clog2(NUM_BINS);

  // Field widths.
  localparam int LAT_W             = 32;
  localparam int CFG_W             = 20;
  localparam int THRESH_W          = 32;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_IDX_W         = 2;
  localparam int OUT_CNT_W         = 32;

  // A bin bound is at most (NUM_BINS - 1) times a CFG_W-bit width.
  localparam int BOUND_W           = CFG_W + $clog2(NUM_BINS);

  // Register reset values.
  localparam logic [CFG_W-1:0]    RST_CAL_OFFSET = CFG_W'(1000);
  localparam logic [CFG_W-1:0]    RST_BIN_WIDTH  = CFG_W'(10000);
  localparam logic [THRESH_W-1:0] RST_THRESHOLD  = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } lhm_op_t;

  // Bin chosen for a latency; ovf set means no bin bound covers it.
  typedef struct packed {
    logic                 ovf;
    logic [BIN_IDX_W-1:0] idx;
  } lhm_bin_sel_t;

endpackage

### rtl/lhm_bin_locate.sv
// Bin locator: keeps the bin upper bounds in registers and picks the first
// bin whose bound is not below a latency. Depends on lhm_pkg.
module lhm_bin_locate
  import lhm_pkg::*;
(
  input  logic               clk,
  input  logic [CFG_W-1:0]   bin_width,
  input  logic [LAT_W-1:0]   lat,
  output lhm_bin_sel_t       sel
);

  logic [BOUND_W-1:0]  bound_r   [NUM_BINS];
  logic [NUM_BINS-1:0] covers;

  // Bounds are registered, so they follow the bin width in the cycle after it changes.
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_BINS; j++) begin
      bound_r[j] <= BOUND_W'(j) * BOUND_W'(bin_width);
    end
  end

  // Each bin compares in parallel.
  always_comb begin
    for (int j = 0; j < NUM_BINS; j++) begin
      covers[j] = (lat <= {{(LAT_W-BOUND_W){1'b0}}, bound_r[j]});
    end
  end

  // The lowest covering bin wins; none means overflow.
  always_comb begin
    sel.ovf = ~(|covers);
    sel.idx = BIN_IDX_W'(NUM_BINS);
    for (int j = NUM_BINS - 1; j >= 0; j--) begin
      if (covers[j]) begin
        sel.idx = BIN_IDX_W'(j);
      end
    end
  end

endmodule

### rtl/latency_histogram_monitor.sv
// Latency histogram monitor: takes one operation per cycle while the output is
// not stalled and returns one result per operation. A transfer on the input is
// registered in the input register, processed against the bin counters and
// statistics, and the result is registered in the output register. The input
// register and the result register make up the pipe; while the output stalls
// the pipe holds and the input stalls once the input register is full. Bin
// bounds are recomputed into registers from the bin width register after a
// write to it. Depends on lhm_pkg and lhm_bin_locate.
module latency_histogram_monitor
  import lhm_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [LAT_W-1:0]      in_raw_latency_ns,
  input  logic [BIN_IDX_W-1:0]  in_read_index,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BIN_IDX_W-1:0]  out_bin_index,
  output logic [OUT_CNT_W-1:0]  out_bin_count,
  output logic [LAT_W-1:0]      out_min_latency_ns,
  output logic [LAT_W-1:0]      out_max_latency_ns,
  output logic [OUT_CNT_W-1:0]  out_largest_bin_count,
  output logic [OUT_CNT_W-1:0]  out_sample_total,
  output logic                  out_threshold_hit
);

  // Configuration registers.
  logic [CFG_W-1:0]    cal_offset_r;
  logic [CFG_W-1:0]    bin_width_r;
  logic [THRESH_W-1:0] threshold_r;

  // Input register.
  logic                 s1_valid_r;
  lhm_op_t              s1_op_r;
  logic [LAT_W-1:0]     s1_raw_r;
  logic [BIN_IDX_W-1:0] s1_idx_r;

  // Statistics.
  logic [COUNT_WIDTH-1:0] bin_cnt_r   [NUM_BINS];
  logic [COUNT_WIDTH-1:0] bin_cnt_nxt [NUM_BINS];
  logic [COUNT_WIDTH-1:0] ovf_cnt_r, ovf_cnt_nxt;
  logic [LAT_W-1:0]       min_r, min_nxt;
  logic [LAT_W-1:0]       max_r, max_nxt;
  logic [COUNT_WIDTH-1:0] peak_r, peak_nxt;
  logic [COUNT_WIDTH-1:0] samples_r, samples_nxt;
  logic                   hit_r, hit_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [BIN_IDX_W-1:0]   res_idx_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic [LAT_W-1:0]       res_min_r;
  logic [LAT_W-1:0]       res_max_r;
  logic [COUNT_WIDTH-1:0] res_peak_r;
  logic [COUNT_WIDTH-1:0] res_samples_r;
  logic                   res_hit_r;

  // Datapath signals.
  logic                   out_free;
  logic                   in_xfer;
  logic                   s1_adv;
  logic [LAT_W-1:0]       cal_offset_ext;
  logic [LAT_W-1:0]       lat;
  lhm_bin_sel_t           sel;
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [LAT_W-1:0]       max_new;
  logic [BIN_IDX_W-1:0]   res_idx;
  logic [COUNT_WIDTH-1:0] res_cnt;

  // Handshake: the result register frees when empty or taken. The input
  // stalls during reset so that no transfer is seen there.
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_adv   = s1_valid_r & out_free;
  assign in_stall = ~rst_n | (s1_valid_r & ~out_free);
  assign in_xfer  = in_valid & ~in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_offset_r <= RST_CAL_OFFSET;
      bin_width_r  <= RST_BIN_WIDTH;
      threshold_r  <= RST_THRESHOLD;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_CAL_OFFSET) begin
        cal_offset_r <= cfg_wr_data[CFG_W-1:0];
      end
      if (cfg_index == CFG_BIN_WIDTH) begin
        bin_width_r <= cfg_wr_data[CFG_W-1:0];
      end
      if (cfg_index == CFG_THRESHOLD) begin
        threshold_r <= cfg_wr_data[THRESH_W-1:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= lhm_op_t'(in_opcode);
      s1_raw_r <= in_raw_latency_ns;
      s1_idx_r <= in_read_index;
    end
  end

  // Corrected latency saturates at zero.
  assign cal_offset_ext = LAT_W'(cal_offset_r);
  assign lat = (s1_raw_r > cal_offset_ext) ? (s1_raw_r - cal_offset_ext) : '0;

  lhm_bin_locate u_locate (
    .clk       (clk),
    .bin_width (bin_width_r),
    .lat       (lat),
    .sel       (sel)
  );

  // One saturating incrementer serves both a bin and the overflow counter.
  assign cnt_old = sel.ovf ? ovf_cnt_r : bin_cnt_r[sel.idx[BIN_ADDR_W-1:0]];
  assign cnt_inc = (&cnt_old) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
  assign max_new = (lat > max_r) ? lat : max_r;

  // Next statistics and the result of the operation.
  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    ovf_cnt_nxt = ovf_cnt_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    peak_nxt    = peak_r;
    samples_nxt = samples_r;
    hit_nxt     = hit_r;
    res_idx     = '0;
    res_cnt     = '0;
    unique case (s1_op_r)
      OP_RECORD: begin
        if (sel.ovf) begin
          ovf_cnt_nxt = cnt_inc;
        end else begin
          bin_cnt_nxt[sel.idx[BIN_ADDR_W-1:0]] = cnt_inc;
          if (cnt_inc > peak_r) begin
            peak_nxt = cnt_inc;
          end
        end
        res_idx     = sel.idx;
        res_cnt     = cnt_inc;
        samples_nxt = (&samples_r) ? samples_r : samples_r + COUNT_WIDTH'(1);
        if (lat < min_r) begin
          min_nxt = lat;
        end
        max_nxt = max_new;
        if ((threshold_r != '0) && (max_new >= threshold_r)) begin
          hit_nxt = 1'b1;
        end
      end
      OP_READ: begin
        res_idx = s1_idx_r;
        if (s1_idx_r < BIN_IDX_W'(NUM_BINS)) begin
          res_cnt = bin_cnt_r[s1_idx_r[BIN_ADDR_W-1:0]];
        end else if (s1_idx_r == BIN_IDX_W'(NUM_BINS)) begin
          res_cnt = ovf_cnt_r;
        end
      end
      OP_CLEAR: begin
        bin_cnt_nxt = '{default: '0};
        ovf_cnt_nxt = '0;
        min_nxt     = '1;
        max_nxt     = '0;
        peak_nxt    = '0;
        samples_nxt = '0;
        hit_nxt     = 1'b0;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Statistics update once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '{default: '0};
      ovf_cnt_r <= '0;
      min_r     <= '1;
      max_r     <= '0;
      peak_r    <= '0;
      samples_r <= '0;
      hit_r     <= 1'b0;
    end else if (s1_adv) begin
      bin_cnt_r <= bin_cnt_nxt;
      ovf_cnt_r <= ovf_cnt_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      peak_r    <= peak_nxt;
      samples_r <= samples_nxt;
      hit_r     <= hit_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload carries the statistics after the operation.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_idx_r     <= res_idx;
      res_cnt_r     <= res_cnt;
      res_min_r     <= min_nxt;
      res_max_r     <= max_nxt;
      res_peak_r    <= peak_nxt;
      res_samples_r <= samples_nxt;
      res_hit_r     <= hit_nxt;
    end
  end

  // Counters are fitted to the 32-bit result fields.
  assign out_valid             = out_valid_r;
  assign out_bin_index         = res_idx_r;
  assign out_bin_count         = OUT_CNT_W'(64'(res_cnt_r));
  assign out_min_latency_ns    = res_min_r;
  assign out_max_latency_ns    = res_max_r;
  assign out_largest_bin_count = OUT_CNT_W'(64'(res_peak_r));
  assign out_sample_total      = OUT_CNT_W'(64'(res_samples_r));
  assign out_threshold_hit     = res_hit_r;

endmodule

### tb/sv/lhm_tb_pkg.sv
// Scoreboard for the latency histogram monitor testbench: an untimed copy of
// the bin counters, statistics and registers, plus a queue of expected results.
// Depends on lhm_pkg.
`timescale 1ns / 1ps
package lhm_tb_pkg;
  import lhm_pkg::*;

  // Register index with no register behind it; writes to it change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One result transfer, field by field.
  typedef struct {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [LAT_W-1:0]     min_latency_ns;
    logic [LAT_W-1:0]     max_latency_ns;
    logic [OUT_CNT_W-1:0] largest_bin_count;
    logic [OUT_CNT_W-1:0] sample_total;
    logic                 threshold_hit;
  } lhm_result_t;

  class histogram_scoreboard;
    logic [CFG_W-1:0]     cal_offset_ns;
    logic [CFG_W-1:0]     bin_width_ns;
    logic [THRESH_W-1:0]  stop_threshold_ns;
    logic [OUT_CNT_W-1:0] bin_hits [NUM_BINS];
    logic [OUT_CNT_W-1:0] overflow_hits;
    logic [LAT_W-1:0]     lowest_ns;
    logic [LAT_W-1:0]     highest_ns;
    logic [OUT_CNT_W-1:0] peak_hits;
    logic [OUT_CNT_W-1:0] samples;
    logic                 hit_flag;
    lhm_result_t          expected_q [$];
    int unsigned          mismatches;
    int unsigned          results_checked;
    int unsigned          op_tally [4];

    function new();
      cal_offset_ns     = RST_CAL_OFFSET;
      bin_width_ns      = RST_BIN_WIDTH;
      stop_threshold_ns = RST_THRESHOLD;
      mismatches        = 0;
      results_checked   = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      clear_stats();
    endfunction

    // Statistics go back to their reset state; registers are kept.
    function void clear_stats();
      foreach (bin_hits[i]) bin_hits[i] = '0;
      overflow_hits = '0;
      lowest_ns     = '1;
      highest_ns    = '0;
      peak_hits     = '0;
      samples       = '0;
      hit_flag      = 1'b0;
    endfunction

    // Counters stop at all ones.
    function logic [OUT_CNT_W-1:0] sat_bump(logic [OUT_CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_CAL_OFFSET: cal_offset_ns     = data[CFG_W-1:0];
        CFG_BIN_WIDTH:  bin_width_ns      = data[CFG_W-1:0];
        CFG_THRESHOLD:  stop_threshold_ns = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Applies one accepted input transfer and queues the result it must produce.
    function void log_operation(logic [1:0] code, logic [LAT_W-1:0] raw,
                                logic [BIN_IDX_W-1:0] idx);
      lhm_result_t      want;
      logic [LAT_W-1:0] lat;
      int               slot;
      want.bin_index = '0;
      want.bin_count = '0;
      op_tally[code]++;
      case (lhm_op_t'(code))
        OP_RECORD: begin
          // Corrected latency saturates at zero below the offset.
          lat = (raw > LAT_W'(cal_offset_ns)) ? raw - LAT_W'(cal_offset_ns) : '0;
          // First bin whose upper bound covers the latency, else overflow.
          slot = NUM_BINS;
          for (int j = NUM_BINS - 1; j >= 0; j--) begin
            if (64'(lat) <= 64'(j) * 64'(bin_width_ns)) slot = j;
          end
          if (slot < NUM_BINS) begin
            bin_hits[slot] = sat_bump(bin_hits[slot]);
            if (bin_hits[slot] > peak_hits) peak_hits = bin_hits[slot];
            want.bin_count = bin_hits[slot];
          end else begin
            overflow_hits  = sat_bump(overflow_hits);
            want.bin_count = overflow_hits;
          end
          want.bin_index = BIN_IDX_W'(slot);
          samples = sat_bump(samples);
          if (lat < lowest_ns) lowest_ns = lat;
          if (lat > highest_ns) highest_ns = lat;
          if (stop_threshold_ns != '0 && highest_ns >= stop_threshold_ns) hit_flag = 1'b1;
        end
        OP_READ: begin
          // Indexes past the overflow slot read as zero.
          want.bin_index = idx;
          if (idx < NUM_BINS) want.bin_count = bin_hits[idx];
          else if (idx == NUM_BINS) want.bin_count = overflow_hits;
        end
        OP_CLEAR: clear_stats();
        default: ;
      endcase
      want.min_latency_ns    = lowest_ns;
      want.max_latency_ns    = highest_ns;
      want.largest_bin_count = peak_hits;
      want.sample_total      = samples;
      want.threshold_hit     = hit_flag;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one result transfer against the oldest expectation.
    function void check_result(lhm_result_t got);
      lhm_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer arrived with no expected result pending");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      compare_field("bin_index", 32'(want.bin_index), 32'(got.bin_index));
      compare_field("bin_count", want.bin_count, got.bin_count);
      compare_field("min_latency_ns", want.min_latency_ns, got.min_latency_ns);
      compare_field("max_latency_ns", want.max_latency_ns, got.max_latency_ns);
      compare_field("largest_bin_count", want.largest_bin_count, got.largest_bin_count);
      compare_field("sample_total", want.sample_total, got.sample_total);
      compare_field("threshold_hit", 32'(want.threshold_hit), 32'(got.threshold_hit));
    endfunction
  endclass

endpackage

### tb/sv/latency_histogram_monitor_tb.sv
// Top-level testbench for latency_histogram_monitor: drives directed and random
// operations under several register settings and idle patterns.
// Depends on lhm_pkg, lhm_tb_pkg and the latency_histogram_monitor RTL.
`timescale 1ns / 1ps
module latency_histogram_monitor_tb;
  import lhm_pkg::*;
  import lhm_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 220;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_opcode;
  logic [LAT_W-1:0]      in_raw_latency_ns;
  logic [BIN_IDX_W-1:0]  in_read_index;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BIN_IDX_W-1:0]  out_bin_index;
  logic [OUT_CNT_W-1:0]  out_bin_count;
  logic [LAT_W-1:0]      out_min_latency_ns;
  logic [LAT_W-1:0]      out_max_latency_ns;
  logic [OUT_CNT_W-1:0]  out_largest_bin_count;
  logic [OUT_CNT_W-1:0]  out_sample_total;
  logic                  out_threshold_hit;

  histogram_scoreboard sb;
  int unsigned         send_gap_pct;
  int unsigned         recv_stall_pct;
  int unsigned         cycle_count = 0;

  latency_histogram_monitor dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_raw_latency_ns     (in_raw_latency_ns),
    .in_read_index         (in_read_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bin_index         (out_bin_index),
    .out_bin_count         (out_bin_count),
    .out_min_latency_ns    (out_min_latency_ns),
    .out_max_latency_ns    (out_max_latency_ns),
    .out_largest_bin_count (out_largest_bin_count),
    .out_sample_total      (out_sample_total),
    .out_threshold_hit     (out_threshold_hit)
  );

  always #2 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_bin_index, out_bin_count, out_min_latency_ns,
                        out_max_latency_ns, out_largest_bin_count,
                        out_sample_total, out_threshold_hit});
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Presents one operation after a random gap and holds it until the transfer.
  task automatic send_op(lhm_op_t op, logic [LAT_W-1:0] raw, logic [BIN_IDX_W-1:0] idx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_raw_latency_ns <= raw;
    in_read_index     <= idx;
    do @(posedge clk); while (in_stall);
    sb.log_operation(op, raw, idx);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= index;
    cfg_wr_data <= data;
    @(posedge clk);
    sb.set_register(index, data);
  endtask

  // Writes all registers; the upper bits of the narrow ones carry junk.
  task automatic apply_settings(logic [CFG_W-1:0] cal, logic [CFG_W-1:0] width,
                                logic [THRESH_W-1:0] thr, bit poke_spare);
    write_register(CFG_CAL_OFFSET, {12'($urandom()), cal});
    write_register(CFG_BIN_WIDTH, {12'($urandom()), width});
    write_register(CFG_THRESHOLD, thr);
    if (poke_spare) write_register(CFG_SPARE, $urandom());
    cfg_wr_en <= 1'b0;
    // Give the bin bounds time to follow the new width.
    repeat (2) @(posedge clk);
  endtask

  // Random operations, mostly records that land in or near the bins.
  task automatic run_random_ops(int unsigned count);
    int unsigned          roll;
    logic [LAT_W-1:0]     span;
    logic [LAT_W-1:0]     raw;
    logic [BIN_IDX_W-1:0] idx;
    lhm_op_t              op;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 2) op = OP_CLEAR;
      else if (roll < 5) op = OP_NOP;
      else if (roll < 35) op = OP_READ;
      else op = OP_RECORD;
      span = sb.bin_width_ns * (NUM_BINS + 1);
      case ($urandom_range(7))
        0: raw = $urandom();
        1: raw = $urandom_range(sb.cal_offset_ns);
        2: raw = sb.cal_offset_ns + sb.bin_width_ns * $urandom_range(NUM_BINS)
                 + $urandom_range(2) - 1;
        default: raw = sb.cal_offset_ns + $urandom_range(span);
      endcase
      idx = ($urandom_range(4) == 0) ? BIN_IDX_W'($urandom_range(31))
                                     : BIN_IDX_W'($urandom_range(NUM_BINS));
      send_op(op, raw, idx);
    end
  endtask

  initial begin
    logic [CFG_W-1:0]    cal;
    logic [CFG_W-1:0]    width;
    logic [THRESH_W-1:0] thr;
    sb             = new();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_CAL_OFFSET;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_NOP;
    in_raw_latency_ns = '0;
    in_read_index  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: offset 1000, width 10000, no threshold.
    send_op(OP_RECORD, 32'd0, 5'd0);             // below the offset
    send_op(OP_RECORD, 32'd1000, 5'd31);         // exactly the offset
    send_op(OP_RECORD, 32'd1001, 5'd0);          // just into bin one
    send_op(OP_RECORD, 32'd11000, 5'd0);         // on the bin one bound
    send_op(OP_RECORD, 32'd11001, 5'd0);         // just past it
    send_op(OP_RECORD, 32'd191000, 5'd0);        // on the last bound
    send_op(OP_RECORD, 32'd191001, 5'd0);        // first overflow
    send_op(OP_RECORD, 32'hFFFF_FFFF, 5'd31);    // largest latency
    send_op(OP_RECORD, 32'd6000, 5'd0);
    send_op(OP_READ, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_READ, 32'd0, 5'd1);
    send_op(OP_READ, 32'd0, 5'd2);
    send_op(OP_READ, 32'd0, 5'd19);
    send_op(OP_READ, 32'd0, 5'(NUM_BINS));       // overflow counter
    send_op(OP_READ, 32'd0, 5'(NUM_BINS + 1));   // past the overflow slot
    send_op(OP_READ, 32'd0, 5'd31);
    send_op(OP_NOP, 32'hA5A5_5A5A, 5'd21);
    send_op(OP_CLEAR, 32'h5A5A_A5A5, 5'd10);
    send_op(OP_READ, 32'd0, 5'd1);
    send_op(OP_READ, 32'd0, 5'(NUM_BINS));
    send_op(OP_RECORD, 32'd1005, 5'd0);
    send_op(OP_READ, 32'd0, 5'd1);

    // Random phases, each with its own settings and idle pattern.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pipe();
      cal   = CFG_W'($urandom_range(1000000));
      width = CFG_W'($urandom_range(1000000, 1));
      thr   = $urandom_range(width * NUM_BINS, 1);
      case (phase)
        0: apply_settings('0, 20'd1, '0, 1'b0);
        1: apply_settings('1, '1, '1, 1'b0);
        // Zero width: only a zero latency lands in a bin.
        2: apply_settings(cal, '0, $urandom_range(100000, 1), 1'b0);
        3: apply_settings(cal, width, thr, 1'b0);
        4: apply_settings(cal, width, thr, 1'b1);
        5: apply_settings(cal, CFG_W'($urandom_range(64, 1)), 32'd1, 1'b0);
        6: apply_settings(RST_CAL_OFFSET, RST_BIN_WIDTH, RST_THRESHOLD, 1'b0);
        default: apply_settings(cal, width, $urandom(), 1'b1);
      endcase
      case (phase % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_gap_pct   = 37;
          recv_stall_pct = 37;
        end
      endcase
      run_random_ops(PHASE_ITEMS);
    end

    drain_pipe();
    $display("Ran %0d records, %0d reads, %0d clears and %0d no-ops over %0d settings.",
             sb.op_tally[OP_RECORD], sb.op_tally[OP_READ], sb.op_tally[OP_CLEAR],
             sb.op_tally[OP_NOP], NUM_PHASES + 1);
    $display("Compared %0d results; %0d field mismatches.", sb.results_checked,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
